// File: src/stl_pkg.sv
package stl_pkg;

  localparam int LINE_WIDTH   = 16;
  localparam int COLUMN_WIDTH = 16;
  localparam int OFFSET_WIDTH = 20;

  localparam int LEN_W  = 20;
  localparam int KIND_W = 5;
  localparam int ERR_W  = 2;
  localparam int KW_N   = 6;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_WORD  = 4'd1,
    M_NUM   = 4'd2,
    M_SLASH = 4'd3,
    M_LINEC = 4'd4,
    M_BLOCK = 4'd5,
    M_BSTAR = 4'd6
  } mode_t;

  typedef enum logic [2:0] {
    NF_DEC  = 3'd0,
    NF_ZERO = 3'd1,
    NF_HEXP = 3'd2,
    NF_HEX  = 3'd3,
    NF_BINP = 3'd4,
    NF_BIN  = 3'd5,
    NF_BAD  = 3'd6
  } nf_t;

  localparam logic [KIND_W-1:0] K_IDENT   = 5'd6;
  localparam logic [KIND_W-1:0] K_INT     = 5'd7;
  localparam logic [KIND_W-1:0] K_COMMENT = 5'd8;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd18;
  localparam logic [KIND_W-1:0] K_NONE    = 5'd0;

  localparam logic [ERR_W-1:0] E_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] E_CHAR   = 2'd1;
  localparam logic [ERR_W-1:0] E_NUMBER = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // keyword text, first character in the top byte
  localparam logic [47:0] KW_TEXT [KW_N] = '{
    {"exit", 16'h0}, {"if", 32'h0}, {"else", 16'h0},
    {"while", 8'h0}, {"func", 16'h0}, "return"
  };
  localparam logic [2:0] KW_LEN [KW_N] = '{3'd4, 3'd2, 3'd4, 3'd5, 3'd4, 3'd6};

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // kind of a one-character symbol, K_NONE when c is none
  function automatic logic [KIND_W-1:0] sym_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h3b:   k = 5'd9;
      8'h28:   k = 5'd10;
      8'h29:   k = 5'd11;
      8'h7b:   k = 5'd12;
      8'h7d:   k = 5'd13;
      8'h3d:   k = 5'd14;
      8'h2b:   k = 5'd15;
      8'h2d:   k = 5'd16;
      8'h2a:   k = 5'd17;
      8'h2f:   k = 5'd18;
      8'h25:   k = 5'd19;
      8'h2c:   k = 5'd20;
      8'h3c:   k = 5'd21;
      8'h3e:   k = 5'd22;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KW_N-1:0] kw_update(input logic [KW_N-1:0] cand,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [7:0] c);
    logic [KW_N-1:0] r;
    logic [5:0] sh;
    r = cand;
    sh = 6'd40 - {len[2:0], 3'b000};
    for (int k = 0; k < KW_N; k++) begin
      if (len >= LEN_W'(KW_LEN[k]) || 8'(KW_TEXT[k] >> sh) != c) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic nf_t nf_next(input nf_t s, input logic [7:0] c);
    nf_t r;
    case (s)
      NF_DEC:  r = is_digit(c) ? NF_DEC : NF_BAD;
      NF_ZERO: begin
        if (is_digit(c)) r = NF_DEC;
        else if (c == 8'h78 || c == 8'h58) r = NF_HEXP;
        else if (c == 8'h62 || c == 8'h42) r = NF_BINP;
        else r = NF_BAD;
      end
      NF_HEXP, NF_HEX: r = is_hex(c) ? NF_HEX : NF_BAD;
      NF_BINP, NF_BIN: r = (c == 8'h30 || c == 8'h31) ? NF_BIN : NF_BAD;
      default: r = NF_BAD;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: src/source_text_lexer.sv
// Streaming lexer: one source byte per item, up to two result items per byte
// (a word, number or pending '/' closed by a byte that is itself a symbol or
// error, or a last byte that starts a token). All lexing is one pass of logic
// from the accepted byte and the lexer state into a two-entry result buffer,
// so an item is taken every cycle while results flow one per cycle; a byte
// that gives two results holds the input while the second result drains.
// Line, column and offset counters saturate at their parameter widths; after
// an error, bytes are dropped until a 0 or 255 byte or the last source byte.
module source_text_lexer #(
  parameter int LINE_WIDTH   = stl_pkg::LINE_WIDTH,
  parameter int COLUMN_WIDTH = stl_pkg::COLUMN_WIDTH,
  parameter int OFFSET_WIDTH = stl_pkg::OFFSET_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_char_code,
  input  logic                       in_last_of_source,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stl_pkg::KIND_W-1:0] out_token_kind,
  output logic [stl_pkg::ERR_W-1:0]  out_error_code,
  output logic [15:0]                out_start_line,
  output logic [15:0]                out_start_column,
  output logic [19:0]                out_text_offset,
  output logic [19:0]                out_text_length,
  output logic                       out_last_in_run
);

  typedef struct packed {
    stl_pkg::mode_t                   mode;
    logic [LINE_WIDTH-1:0]            line;
    logic [COLUMN_WIDTH-1:0]          col;
    logic [OFFSET_WIDTH-1:0]          off;
    logic [LINE_WIDTH-1:0]            s_line;
    logic [COLUMN_WIDTH-1:0]          s_col;
    logic [OFFSET_WIDTH-1:0]          s_off;
    logic [stl_pkg::LEN_W-1:0]        len;
    logic [stl_pkg::KW_N-1:0]         cand;
    stl_pkg::nf_t                     nf;
    logic                             drop;
  } lex_st_t;

  typedef struct packed {
    logic [stl_pkg::KIND_W-1:0] kind;
    logic [stl_pkg::ERR_W-1:0]  err;
    logic [15:0]                line;
    logic [15:0]                col;
    logic [19:0]                off;
    logic [19:0]                len;
    logic                       last;
  } res_t;

  function automatic lex_st_t st_reset();
    lex_st_t s;
    s.mode   = stl_pkg::M_IDLE;
    s.line   = LINE_WIDTH'(1);
    s.col    = COLUMN_WIDTH'(1);
    s.off    = '0;
    s.s_line = LINE_WIDTH'(1);
    s.s_col  = COLUMN_WIDTH'(1);
    s.s_off  = '0;
    s.len    = '0;
    s.cand   = '1;
    s.nf     = stl_pkg::NF_DEC;
    s.drop   = 1'b0;
    return s;
  endfunction

  function automatic lex_st_t advance(input lex_st_t s, input logic [7:0] c);
    lex_st_t r;
    r = s;
    if (s.off != '1) r.off = s.off + 1'b1;
    if (c == 8'h0a) begin
      if (s.line != '1) r.line = s.line + 1'b1;
      r.col = COLUMN_WIDTH'(1);
    end else if (s.col != '1) begin
      r.col = s.col + 1'b1;
    end
    return r;
  endfunction

  function automatic lex_st_t mark_start(input lex_st_t s);
    lex_st_t r;
    r = s;
    r.s_line = s.line;
    r.s_col  = s.col;
    r.s_off  = s.off;
    return r;
  endfunction

  function automatic res_t mk_res(input logic [stl_pkg::KIND_W-1:0] kind,
                                  input logic [stl_pkg::ERR_W-1:0] err,
                                  input logic [LINE_WIDTH-1:0] line,
                                  input logic [COLUMN_WIDTH-1:0] col,
                                  input logic [OFFSET_WIDTH-1:0] off,
                                  input logic [stl_pkg::LEN_W-1:0] len);
    res_t r;
    r.kind = kind;
    r.err  = err;
    r.line = 16'(line);
    r.col  = 16'(col);
    r.off  = 20'(off);
    r.len  = 20'(len);
    r.last = 1'b0;
    return r;
  endfunction

  function automatic res_t word_res(input lex_st_t s);
    logic [stl_pkg::KIND_W-1:0] kind;
    kind = stl_pkg::K_IDENT;
    for (int k = stl_pkg::KW_N - 1; k >= 0; k--) begin
      if (s.cand[k] && s.len == stl_pkg::LEN_W'(stl_pkg::KW_LEN[k]))
        kind = stl_pkg::KIND_W'(k);
    end
    return mk_res(kind, stl_pkg::E_NONE, s.s_line, s.s_col, s.s_off, s.len);
  endfunction

  function automatic logic nf_ok(input stl_pkg::nf_t nf);
    return nf == stl_pkg::NF_DEC || nf == stl_pkg::NF_ZERO ||
           nf == stl_pkg::NF_HEX || nf == stl_pkg::NF_BIN;
  endfunction

  lex_st_t st_r, st_nxt, s;
  res_t    q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  res_t    e [2];
  logic [1:0] n;
  logic    do_idle, src_end, in_acc, out_pop;
  logic [7:0] c;
  logic [stl_pkg::KIND_W-1:0] sk;

  assign c       = in_char_code;
  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_valid = (cnt_r != 2'd0);
  assign in_acc    = in_valid && in_ready;
  assign out_pop   = out_valid && out_ready;
  assign sk        = stl_pkg::sym_kind(c);

  always_comb begin
    s = st_r;
    n = 2'd0;
    e[0] = '0;
    e[1] = '0;
    do_idle = 1'b0;
    src_end = (c == 8'h00) || (c == 8'hff);
    if (st_r.drop) begin
      if (src_end || in_last_of_source) s = st_reset();
    end else begin
      if (!src_end) begin
        case (s.mode)
          stl_pkg::M_WORD: begin
            if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c) || c == 8'h5f) begin
              s.cand = stl_pkg::kw_update(s.cand, s.len, c);
              s.len  = stl_pkg::len_inc(s.len);
              s = advance(s, c);
            end else begin
              e[n[0]] = word_res(s);
              n = n + 2'd1;
              s.mode = stl_pkg::M_IDLE;
              do_idle = 1'b1;
            end
          end
          stl_pkg::M_NUM: begin
            if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
              s.nf  = stl_pkg::nf_next(s.nf, c);
              s.len = stl_pkg::len_inc(s.len);
              s = advance(s, c);
            end else begin
              s.mode = stl_pkg::M_IDLE;
              if (nf_ok(s.nf)) begin
                e[n[0]] = mk_res(stl_pkg::K_INT, stl_pkg::E_NONE, s.s_line, s.s_col,
                                 s.s_off, s.len);
                do_idle = 1'b1;
              end else begin
                e[n[0]] = mk_res(stl_pkg::K_NONE, stl_pkg::E_NUMBER, s.s_line, s.s_col,
                                 s.s_off, s.len);
                s.drop = 1'b1;
              end
              n = n + 2'd1;
            end
          end
          stl_pkg::M_SLASH: begin
            if (c == 8'h2f || c == 8'h2a) begin
              s.mode = (c == 8'h2f) ? stl_pkg::M_LINEC : stl_pkg::M_BLOCK;
              s = advance(s, c);
              s.s_off = s.off;
              s.len = '0;
            end else begin
              e[n[0]] = mk_res(stl_pkg::K_SLASH, stl_pkg::E_NONE, s.s_line, s.s_col,
                               s.s_off, stl_pkg::LEN_W'(1));
              n = n + 2'd1;
              s.mode = stl_pkg::M_IDLE;
              do_idle = 1'b1;
            end
          end
          stl_pkg::M_LINEC: begin
            if (c == 8'h0a) begin
              e[n[0]] = mk_res(stl_pkg::K_COMMENT, stl_pkg::E_NONE, s.s_line, s.s_col,
                               s.s_off, s.len);
              n = n + 2'd1;
              s.mode = stl_pkg::M_IDLE;
              do_idle = 1'b1;
            end else begin
              s.len = stl_pkg::len_inc(s.len);
              s = advance(s, c);
            end
          end
          stl_pkg::M_BLOCK: begin
            if (c == 8'h2a) s.mode = stl_pkg::M_BSTAR;
            else s.len = stl_pkg::len_inc(s.len);
            s = advance(s, c);
          end
          stl_pkg::M_BSTAR: begin
            if (c == 8'h2f) begin
              s = advance(s, c);
              e[n[0]] = mk_res(stl_pkg::K_COMMENT, stl_pkg::E_NONE, s.s_line, s.s_col,
                               s.s_off, s.len);
              n = n + 2'd1;
              s.mode = stl_pkg::M_IDLE;
            end else begin
              // the held '*' was content after all
              s.len = stl_pkg::len_inc(s.len);
              if (c != 8'h2a) begin
                s.len = stl_pkg::len_inc(s.len);
                s.mode = stl_pkg::M_BLOCK;
              end
              s = advance(s, c);
            end
          end
          default: begin
            s.mode = stl_pkg::M_IDLE;
            do_idle = 1'b1;
          end
        endcase

        if (do_idle) begin
          if (stl_pkg::is_space(c)) begin
            s = advance(s, c);
          end else if (stl_pkg::is_alpha(c) || c == 8'h5f) begin
            s = mark_start(s);
            s.cand = stl_pkg::kw_update('1, '0, c);
            s.len  = stl_pkg::LEN_W'(1);
            s.mode = stl_pkg::M_WORD;
            s = advance(s, c);
          end else if (stl_pkg::is_digit(c)) begin
            s = mark_start(s);
            s.len  = stl_pkg::LEN_W'(1);
            s.nf   = (c == 8'h30) ? stl_pkg::NF_ZERO : stl_pkg::NF_DEC;
            s.mode = stl_pkg::M_NUM;
            s = advance(s, c);
          end else if (c == 8'h2f) begin
            s = mark_start(s);
            s.len  = stl_pkg::LEN_W'(1);
            s.mode = stl_pkg::M_SLASH;
            s = advance(s, c);
          end else if (sk != stl_pkg::K_NONE) begin
            e[n[0]] = mk_res(sk, stl_pkg::E_NONE, s.line, s.col, s.off,
                             stl_pkg::LEN_W'(1));
            n = n + 2'd1;
            s = advance(s, c);
          end else begin
            e[n[0]] = mk_res(stl_pkg::K_NONE, stl_pkg::E_CHAR, s.line, s.col, s.off,
                             stl_pkg::LEN_W'(1));
            n = n + 2'd1;
            s.drop = 1'b1;
          end
        end
      end

      // end of source: flush the pending token, then start over
      if (src_end || in_last_of_source) begin
        if (!s.drop) begin
          case (s.mode)
            stl_pkg::M_WORD: begin
              e[n[0]] = word_res(s);
              n = n + 2'd1;
            end
            stl_pkg::M_NUM: begin
              e[n[0]] = nf_ok(s.nf)
                ? mk_res(stl_pkg::K_INT, stl_pkg::E_NONE, s.s_line, s.s_col, s.s_off, s.len)
                : mk_res(stl_pkg::K_NONE, stl_pkg::E_NUMBER, s.s_line, s.s_col, s.s_off,
                         s.len);
              n = n + 2'd1;
            end
            stl_pkg::M_SLASH: begin
              e[n[0]] = mk_res(stl_pkg::K_SLASH, stl_pkg::E_NONE, s.s_line, s.s_col,
                               s.s_off, stl_pkg::LEN_W'(1));
              n = n + 2'd1;
            end
            stl_pkg::M_BSTAR: begin
              e[n[0]] = mk_res(stl_pkg::K_COMMENT, stl_pkg::E_NONE, s.s_line, s.s_col,
                               s.s_off, stl_pkg::len_inc(s.len));
              n = n + 2'd1;
            end
            stl_pkg::M_LINEC, stl_pkg::M_BLOCK: begin
              e[n[0]] = mk_res(stl_pkg::K_COMMENT, stl_pkg::E_NONE, s.s_line, s.s_col,
                               s.s_off, s.len);
              n = n + 2'd1;
            end
            default: ;
          endcase
        end
        s = st_reset();
      end
    end
    if (n == 2'd1) e[0].last = 1'b1;
    if (n == 2'd2) e[1].last = 1'b1;
  end

  always_comb begin
    st_nxt  = st_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      st_nxt  = s;
      q0_nxt  = e[0];
      q1_nxt  = e[1];
      cnt_nxt = n;
    end else if (out_pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= st_reset();
      cnt_r <= 2'd0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_token_kind   = q0_r.kind;
  assign out_error_code   = q0_r.err;
  assign out_start_line   = q0_r.line;
  assign out_start_column = q0_r.col;
  assign out_text_offset  = q0_r.off;
  assign out_text_length  = q0_r.len;
  assign out_last_in_run  = q0_r.last;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result buffer count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r == 2'd0 || out_pop)) else $error("item taken over pending results");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && q0_r.err != stl_pkg::E_NONE |-> q0_r.kind == stl_pkg::K_NONE)
    else $error("error result carries a token kind");

  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> (!q0_r.last && q1_r.last)) else $error("run end marker misplaced");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

class lexer_scoreboard;
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [15:0] line;
    logic [15:0] col;
    logic [19:0] off;
    logic [19:0] len;
    logic        last;
  } token_t;

  token_t pending_tokens[$];
  int mismatches;

  // lexer state
  stl_pkg::mode_t mode;
  stl_pkg::nf_t nfs;
  logic [15:0] line_cnt, col_cnt, tok_line, tok_col;
  logic [19:0] byte_off, tok_off, tok_len;
  logic [5:0] cands;
  bit dropping;
  token_t run[$];

  function new();
    mismatches = 0;
    clear_state();
  endfunction

  function void clear_state();
    mode = stl_pkg::M_IDLE;
    nfs = stl_pkg::NF_DEC;
    line_cnt = 1; col_cnt = 1; tok_line = 1; tok_col = 1;
    byte_off = 0; tok_off = 0; tok_len = 0;
    cands = '1;
    dropping = 0;
  endfunction

  function bit digit(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
  function bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function bit hexd(logic [7:0] c);
    return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function bit blank(logic [7:0] c); return c == " " || (c >= 9 && c <= 13); endfunction

  function logic [19:0] inc20(logic [19:0] v); return &v ? v : v + 1; endfunction
  function logic [15:0] inc16(logic [15:0] v); return &v ? v : v + 1; endfunction

  function void push(logic [4:0] k, logic [1:0] e, logic [15:0] l, logic [15:0] c,
                     logic [19:0] o, logic [19:0] n);
    token_t t;
    t = '{k, e, l, c, o, n, 1'b0};
    run.insert(run.size(), t);
  endfunction

  function void step_pos(logic [7:0] c);
    byte_off = inc20(byte_off);
    if (c == 8'h0a) begin
      line_cnt = inc16(line_cnt);
      col_cnt = 1;
    end else begin
      col_cnt = inc16(col_cnt);
    end
  endfunction

  function void mark();
    tok_line = line_cnt; tok_col = col_cnt; tok_off = byte_off;
  endfunction

  function void match_kw(logic [7:0] c);
    string kw[6] = '{"exit", "if", "else", "while", "func", "return"};
    for (int k = 0; k < 6; k++)
      if (tok_len >= kw[k].len() || kw[k][tok_len] != c) cands[k] = 0;
  endfunction

  function void lex_fresh(logic [7:0] c);
    string syms = ";(){}=+-*/%,<>";
    if (blank(c)) begin
      step_pos(c);
      return;
    end
    if (alpha(c) || c == "_") begin
      mark(); cands = '1; tok_len = 0; match_kw(c); tok_len = 1;
      mode = stl_pkg::M_WORD; step_pos(c);
      return;
    end
    if (digit(c)) begin
      mark(); tok_len = 1;
      nfs = (c == "0") ? stl_pkg::NF_ZERO : stl_pkg::NF_DEC;
      mode = stl_pkg::M_NUM; step_pos(c);
      return;
    end
    if (c == "/") begin
      mark(); tok_len = 1; mode = stl_pkg::M_SLASH; step_pos(c);
      return;
    end
    for (int k = 0; k < 14; k++)
      if (syms[k] == c) begin
        push(5'(9 + k), stl_pkg::E_NONE, line_cnt, col_cnt, byte_off, 1);
        step_pos(c);
        return;
      end
    push(stl_pkg::K_NONE, stl_pkg::E_CHAR, line_cnt, col_cnt, byte_off, 1);
    dropping = 1;
  endfunction

  function void close_word();
    int lens[6] = '{4, 2, 4, 5, 4, 6};
    logic [4:0] k = stl_pkg::K_IDENT;
    for (int i = 5; i >= 0; i--)
      if (cands[i] && tok_len == lens[i]) k = 5'(i);
    mode = stl_pkg::M_IDLE;
    push(k, stl_pkg::E_NONE, tok_line, tok_col, tok_off, tok_len);
  endfunction

  function void close_number();
    mode = stl_pkg::M_IDLE;
    if (nfs inside {stl_pkg::NF_DEC, stl_pkg::NF_ZERO, stl_pkg::NF_HEX, stl_pkg::NF_BIN})
      push(stl_pkg::K_INT, stl_pkg::E_NONE, tok_line, tok_col, tok_off, tok_len);
    else begin
      dropping = 1;
      push(stl_pkg::K_NONE, stl_pkg::E_NUMBER, tok_line, tok_col, tok_off, tok_len);
    end
  endfunction

  function void close_comment();
    mode = stl_pkg::M_IDLE;
    push(stl_pkg::K_COMMENT, stl_pkg::E_NONE, tok_line, tok_col, tok_off, tok_len);
  endfunction

  function void flush_pending();
    case (mode)
      stl_pkg::M_WORD: close_word();
      stl_pkg::M_NUM: close_number();
      stl_pkg::M_SLASH: begin
        mode = stl_pkg::M_IDLE;
        push(stl_pkg::K_SLASH, stl_pkg::E_NONE, tok_line, tok_col, tok_off, 1);
      end
      stl_pkg::M_BSTAR: begin
        tok_len = inc20(tok_len);
        close_comment();
      end
      stl_pkg::M_LINEC, stl_pkg::M_BLOCK: close_comment();
      default: ;
    endcase
  endfunction

  function logic [2:0] next_format(logic [2:0] s, logic [7:0] c);
    case (s)
      stl_pkg::NF_DEC: return digit(c) ? stl_pkg::NF_DEC : stl_pkg::NF_BAD;
      stl_pkg::NF_ZERO:
        if (digit(c)) return stl_pkg::NF_DEC;
        else if (c == "x" || c == "X") return stl_pkg::NF_HEXP;
        else if (c == "b" || c == "B") return stl_pkg::NF_BINP;
        else return stl_pkg::NF_BAD;
      stl_pkg::NF_HEXP, stl_pkg::NF_HEX: return hexd(c) ? stl_pkg::NF_HEX : stl_pkg::NF_BAD;
      stl_pkg::NF_BINP, stl_pkg::NF_BIN:
        return (c == "0" || c == "1") ? stl_pkg::NF_BIN : stl_pkg::NF_BAD;
      default: return stl_pkg::NF_BAD;
    endcase
  endfunction

  function void note_char(logic [7:0] c, logic last);
    run.delete();
    if (dropping) begin
      if (c == 0 || c == 8'hff || last) clear_state();
      return;
    end
    if (c == 0 || c == 8'hff) begin
      flush_pending();
      clear_state();
    end else begin
      case (mode)
        stl_pkg::M_WORD:
          if (alpha(c) || digit(c) || c == "_") begin
            match_kw(c); tok_len = inc20(tok_len); step_pos(c);
          end else begin
            close_word(); lex_fresh(c);
          end
        stl_pkg::M_NUM:
          if (alpha(c) || digit(c)) begin
            nfs = stl_pkg::nf_t'(next_format(nfs, c));
            tok_len = inc20(tok_len); step_pos(c);
          end else begin
            close_number();
            if (!dropping) lex_fresh(c);
          end
        stl_pkg::M_SLASH:
          if (c == "/" || c == "*") begin
            mode = (c == "/") ? stl_pkg::M_LINEC : stl_pkg::M_BLOCK;
            step_pos(c); tok_off = byte_off; tok_len = 0;
          end else begin
            push(stl_pkg::K_SLASH, stl_pkg::E_NONE, tok_line, tok_col, tok_off, 1);
            mode = stl_pkg::M_IDLE;
            lex_fresh(c);
          end
        stl_pkg::M_LINEC:
          if (c == 8'h0a) begin
            close_comment(); lex_fresh(c);
          end else begin
            tok_len = inc20(tok_len); step_pos(c);
          end
        stl_pkg::M_BLOCK: begin
          if (c == "*") mode = stl_pkg::M_BSTAR;
          else tok_len = inc20(tok_len);
          step_pos(c);
        end
        stl_pkg::M_BSTAR:
          if (c == "/") begin
            step_pos(c); close_comment();
          end else begin
            // the held star turns out to be content
            tok_len = inc20(tok_len);
            if (c != "*") begin
              tok_len = inc20(tok_len);
              mode = stl_pkg::M_BLOCK;
            end
            step_pos(c);
          end
        default: begin
          mode = stl_pkg::M_IDLE;
          lex_fresh(c);
        end
      endcase
      if (last) begin
        if (!dropping) flush_pending();
        clear_state();
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1;
    foreach (run[i]) pending_tokens.insert(pending_tokens.size(), run[i]);
  endfunction

  function void check_token(token_t got);
    token_t want;
    if (pending_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected token item %h", got);
      return;
    end
    want = pending_tokens.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("token mismatch: want kind %0d err %0d line %0d col %0d off %0d len %0d last %0d, got kind %0d err %0d line %0d col %0d off %0d len %0d last %0d",
                 want.kind, want.err, want.line, want.col, want.off, want.len, want.last,
                 got.kind, got.err, got.line, got.col, got.off, got.len, got.last);
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] in_char_code = 0;
  logic in_last_of_source = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [4:0] out_token_kind;
  logic [1:0] out_error_code;
  logic [15:0] out_start_line, out_start_column;
  logic [19:0] out_text_offset, out_text_length;
  logic out_last_in_run;

  lexer_scoreboard lexer_sb = new();
  int idle_cycles = 0;
  bit draining = 0;
  bit sink_steady = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  source_text_lexer dut (.*);

  function int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      lexer_sb.check_token({out_token_kind, out_error_code, out_start_line,
                            out_start_column, out_text_offset, out_text_length,
                            out_last_in_run});
    if (rst_n && in_valid && in_ready)
      lexer_sb.note_char(in_char_code, in_last_of_source);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("source_text_lexer regression: fail");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      out_ready <= 1;
      @(posedge clk);
      if (!sink_steady && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    int g;
    g = draining ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_char_code <= c;
    in_last_of_source <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(string s, logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_at_end && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (lexer_sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function string pick_piece();
    string pieces[] = '{"exit", "if", "else", "while", "func", "return", "ifx",
                        "retur", "_a9", "x", "0x1F", "0b101", "007", "0", "0x",
                        "0b2", "12a", "//c\n", "/*a*b**/", "/", "/*x", " ", "\n",
                        "\t", ";", "(", ")", "{", "}", "=", "+", "-", "*", "%",
                        ",", "<", ">", "0XaB", "0B1"};
    return pieces[$urandom_range(0, pieces.size() - 1)];
  endfunction

  initial begin
    int sent;
    string s;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: keywords, symbols, number forms, comments, edge bytes
    send_text("exit if else while func return foo_1\n", 0);
    send_text(";(){}=+-*/%,<>", 0);
    send_text("0x1f 0b10 123 0 ", 0);
    send_text("//line\n/*bl*k*/ /", 1);
    send_text("/*open*", 1);
    send_text("0x;", 0);
    send_char(8'h00, 0);
    send_text("12@", 0);
    send_text("zz", 0);
    send_char(8'hff, 0);
    send_char(8'h80, 0);
    send_char(8'h41, 1);
    send_char(8'hfe, 1);
    send_char(8'h7f, 1);

    // pause until every token is out
    draining = 1;
    wait_drained();
    draining = 0;

    sent = 0;
    while (sent < 650) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise byte, any value
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        sent++;
      end else begin
        s = pick_piece();
        send_text(s, $urandom_range(0, 30) == 0);
        sent += s.len();
      end
      if ($urandom_range(0, 200) == 0) begin
        sink_steady = $urandom_range(0, 1);
      end
    end

    sink_steady = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (lexer_sb.mismatches == 0 && lexer_sb.pending_tokens.size() == 0)
      $display("source_text_lexer regression: pass");
    else
      $display("source_text_lexer regression: fail");
    $finish;
  end
endmodule
